FILE: rtl/assert_macros.svh
// Assertion macros used by the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/ffca_pkg.sv
// Shared constants and types of the first-fit chunk allocator.
package ffca_pkg;
    localparam int PoolBytes = 256;
    localparam int MaxChunks = 32;
    localparam int OffW = $clog2(PoolBytes);
    localparam int SizeW = 9;
    localparam int IdxW = $clog2(MaxChunks);
    localparam int CntW = IdxW + 1;
    localparam int PosW = OffW + 2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ZERO = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_NOFIT = 3'd3;
    localparam logic [2:0] ST_BADFREE = 3'd4;
    localparam logic [2:0] ST_NULL = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture request, clear offset and index
        logic rd;          // issue table read at current index
        logic next_entry;  // advance entry index
        logic next_off;    // advance candidate offset, restart index
        logic append;      // write new chunk at count
        logic shift;       // issue table read at index+1
        logic move;        // write the read entry down to index, advance index
        logic dec_count;
    } ffca_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic is_null;
        logic size_zero;
        logic full;
        logic off_ok;      // candidate range lies inside the pool
        logic idx_end;     // index has reached count
        logic shift_end;   // index+1 has reached count
        logic hit;         // registered entry overlaps / matches
    } ffca_sts_t;
endpackage

FILE: rtl/ffca_datapath.sv
// Datapath of the allocator: chunk table, count, candidate offset and compare.
module ffca_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ffca_pkg::ffca_cmd_t  cmd,
    output ffca_pkg::ffca_sts_t  sts,
    input  logic                 in_kind,
    input  logic [8:0]           in_size,
    input  logic [7:0]           in_foff,
    input  logic                 in_null,
    input  logic [6:0]           align_step,
    output logic [7:0]           off_low
);
    import ffca_pkg::*;

    logic [OffW-1:0]  start_mem [MaxChunks];
    logic [SizeW-1:0] len_mem [MaxChunks];
    logic [OffW-1:0]  rd_start_reg;
    logic [SizeW-1:0] rd_len_reg;
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  idx_reg;
    logic [PosW-1:0]  off_reg;
    logic             kind_reg, null_reg;
    logic [SizeW-1:0] size_reg;
    logic [7:0]       foff_reg;
    logic [6:0]       step;
    logic [IdxW-1:0]  rd_addr;
    logic [CntW-1:0]  idx_plus;

    assign step = (align_step == 7'd0) ? 7'd1 : align_step;
    assign idx_plus = idx_reg + 1'b1;
    // A shift reads the following entry; a scan reads the current one.
    assign rd_addr = cmd.shift ? idx_plus[IdxW-1:0] : idx_reg[IdxW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;
            size_reg <= in_size;
            foff_reg <= in_foff;
            null_reg <= in_null;
        end
        if (cmd.rd || cmd.shift) begin
            rd_start_reg <= start_mem[rd_addr];
            rd_len_reg <= len_mem[rd_addr];
        end
        if (cmd.append) begin
            start_mem[count_reg[IdxW-1:0]] <= off_reg[OffW-1:0];
            len_mem[count_reg[IdxW-1:0]] <= size_reg;
        end else if (cmd.move) begin
            start_mem[idx_reg[IdxW-1:0]] <= rd_start_reg;
            len_mem[idx_reg[IdxW-1:0]] <= rd_len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg <= '0;
            off_reg <= '0;
        end else begin
            if (cmd.append) count_reg <= count_reg + 1'b1;
            else if (cmd.dec_count) count_reg <= count_reg - 1'b1;
            if (cmd.load) begin
                idx_reg <= '0;
                off_reg <= '0;
            end else if (cmd.next_off) begin
                idx_reg <= '0;
                off_reg <= off_reg + PosW'(step);
            end else if (cmd.next_entry || cmd.move) begin
                idx_reg <= idx_plus;
            end
        end
    end

    logic [PosW+1:0] off_end, ent_end;
    assign off_end = (PosW+2)'(off_reg) + (PosW+2)'(size_reg);
    assign ent_end = (PosW+2)'(rd_start_reg) + (PosW+2)'(rd_len_reg);

    always_comb begin
        sts.is_free = kind_reg;
        sts.is_null = null_reg;
        sts.size_zero = (size_reg == '0);
        sts.full = (count_reg >= CntW'(MaxChunks));
        sts.off_ok = (off_end <= (PosW+2)'(PoolBytes));
        sts.idx_end = (idx_reg == count_reg);
        sts.shift_end = (idx_plus >= count_reg);
        if (kind_reg)
            sts.hit = ((PosW+2)'(rd_start_reg) == (PosW+2)'(foff_reg));
        else
            sts.hit = ((PosW+2)'(rd_start_reg) < off_end) &&
                      ((PosW+2)'(off_reg) < ent_end);
    end

    assign off_low = off_reg[7:0];
endmodule

FILE: rtl/ffca_ctrl.sv
// Controller state machine of the allocator.
module ffca_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           out_status,
    output logic                 grant_sel,
    output ffca_pkg::ffca_cmd_t  cmd,
    input  ffca_pkg::ffca_sts_t  sts
);
    import ffca_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_READ, S_CHECK, S_SHIFT, S_MOVE, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] status_reg, status_next;
    logic       grant_reg, grant_next;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_status = status_reg;
    assign grant_sel = grant_reg;

    always_comb begin
        state_next = state_reg;
        status_next = status_reg;
        grant_next = grant_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                grant_next = 1'b0;
                state_next = S_DONE;
                if (sts.is_free) begin
                    if (sts.is_null) status_next = ST_NULL;
                    else state_next = S_READ;
                end else if (sts.size_zero) status_next = ST_ZERO;
                else if (sts.full) status_next = ST_FULL;
                else state_next = S_READ;
            end
            S_READ: begin
                if (!sts.is_free && !sts.off_ok) begin
                    status_next = ST_NOFIT;
                    state_next = S_DONE;
                end else if (sts.idx_end) begin
                    state_next = S_DONE;
                    if (sts.is_free) status_next = ST_BADFREE;
                    else begin
                        cmd.append = 1'b1;
                        status_next = ST_OK;
                        grant_next = 1'b1;
                    end
                end else begin
                    cmd.rd = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.hit) begin
                    if (sts.is_free) begin
                        status_next = ST_OK;
                        state_next = S_SHIFT;
                    end else begin
                        cmd.next_off = 1'b1;
                        state_next = S_READ;
                    end
                end else begin
                    cmd.next_entry = 1'b1;
                    state_next = S_READ;
                end
            end
            S_SHIFT: begin
                if (sts.shift_end) begin
                    cmd.dec_count = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.shift = 1'b1;
                    state_next = S_MOVE;
                end
            end
            S_MOVE: begin
                cmd.move = 1'b1;
                state_next = S_SHIFT;
            end
            S_DONE: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            status_reg <= ST_OK;
            grant_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            status_reg <= status_next;
            grant_reg <= grant_next;
        end
    end
endmodule

FILE: rtl/first_fit_chunk_allocator_core.sv
// Each request takes one input word and gives one result word, and a new request is taken
// only after the result has been taken. Zero-size, table-full and null-pointer requests
// go from the decide state straight to the result. An allocate walks candidate offsets
// from 0 in align_step strides and reads the stored chunks through a single table port,
// one chunk read at a time. A free reads the stored chunks the same way until one starts
// at the free offset, then moves each later entry down, reading it in the shift state
// and writing it in the move state.
// Results carry status and, on a successful allocate, the granted offset.
module first_fit_chunk_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // request_size[8:0], free_offset[16:9], pad
    input  logic [1:0]  s_tuser,   // kind[0], null_pointer[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[2:0], granted_offset[10:3], pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffca_pkg::*;
    `include "assert_macros.svh"

    ffca_cmd_t  cmd;
    ffca_sts_t  sts;
    logic [6:0] align_reg;
    logic [2:0] status;
    logic       grant_sel;
    logic [7:0] off_low;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {25'd0, align_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) align_reg <= 7'd1;
        else if (psel && penable && pwrite && paddr == 3'd0) align_reg <= pwdata[6:0];
    end

    ffca_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_status(status), .grant_sel(grant_sel),
        .cmd(cmd), .sts(sts)
    );

    ffca_datapath u_dp (
        .aclk, .aresetn, .cmd(cmd), .sts(sts),
        .in_kind(s_tuser[0]), .in_size(s_tdata[8:0]), .in_foff(s_tdata[16:9]),
        .in_null(s_tuser[1]), .align_step(align_reg), .off_low(off_low)
    );

    assign m_tdata = {5'd0, (grant_sel ? off_low : 8'd0), status};

    `ASSERT_IMPL(a_ready_excl, aclk, aresetn, s_tready, !m_tvalid,
        "input ready while result pending")
    `ASSERT_IMPL(a_grant_ok, aclk, aresetn, m_tvalid && grant_sel, status == ST_OK,
        "grant without ok status")
    `ASSERT_NEXT(a_one_op, aclk, aresetn, cmd.append, !cmd.shift,
        "append followed by shift")
endmodule
